[hw/rtl/vbp_pkg.sv]
// ----------------------------------------------------------------------------
// vbp_pkg
// shared constants, item types and helper functions of the vliw bundle packer
// ----------------------------------------------------------------------------
package vbp_pkg;

    localparam int NUM_CHANNELS           = 6;
    localparam int CH_BITS                = $clog2(NUM_CHANNELS);
    localparam int OP_BITS                = 8;
    localparam int REG_BITS               = 8;
    localparam int CLASS_BITS             = 3;
    localparam int STATUS_BITS            = 2;
    localparam int COUNT_BITS             = 3;
    localparam int DEFAULT_REG_INDEX_BITS = 8;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_PLACED     = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_HAZARD     = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NO_CHANNEL = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_SKIPPED    = 2'd3;

    // unit classes
    localparam logic [CLASS_BITS-1:0] CLASS_NONE = 3'd0;
    localparam logic [CLASS_BITS-1:0] CLASS_ALU  = 3'd1;
    localparam logic [CLASS_BITS-1:0] CLASS_MUL  = 3'd2;
    localparam logic [CLASS_BITS-1:0] CLASS_DIV  = 3'd3;
    localparam logic [CLASS_BITS-1:0] CLASS_MEM  = 3'd4;

    // allowed channel sets
    localparam logic [NUM_CHANNELS-1:0] CH_MASK_NONE = 6'h00;
    localparam logic [NUM_CHANNELS-1:0] CH_MASK_ALU  = 6'h0F;
    localparam logic [NUM_CHANNELS-1:0] CH_MASK_MUL  = 6'h03;
    localparam logic [NUM_CHANNELS-1:0] CH_MASK_DIV  = 6'h01;
    localparam logic [NUM_CHANNELS-1:0] CH_MASK_MEM  = 6'h30;

    typedef struct packed {
        logic [OP_BITS-1:0]    op_code;
        logic [CLASS_BITS-1:0] unit_class;
        logic                  dest_valid;
        logic [REG_BITS-1:0]   dest_reg;
        logic                  src_a_valid;
        logic [REG_BITS-1:0]   src_a_reg;
        logic                  src_b_valid;
        logic [REG_BITS-1:0]   src_b_reg;
        logic                  last_in_group;
    } item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [CH_BITS-1:0]     channel;
        logic [OP_BITS-1:0]     slot_op;
        logic [REG_BITS-1:0]    slot_dest;
        logic [REG_BITS-1:0]    slot_src_a;
        logic [REG_BITS-1:0]    slot_src_b;
        logic [COUNT_BITS-1:0]  placed_count;
    } result_t;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0]               busy_mask;
        logic [NUM_CHANNELS-1:0]               written_valid;
        logic [NUM_CHANNELS-1:0][REG_BITS-1:0] written_regs;
        logic                                  bundle_closed;
        logic [COUNT_BITS-1:0]                 placed_total;
    } state_t;

    typedef struct packed {
        logic                place;
        logic                close;
        logic                clear;
        logic [CH_BITS-1:0]  pick;
        logic                write_dest;
        logic [REG_BITS-1:0] dest_reg;
    } update_t;

    function automatic logic [NUM_CHANNELS-1:0] class_mask(input logic [CLASS_BITS-1:0] cls);
        logic [NUM_CHANNELS-1:0] m;
        unique case (cls)
            CLASS_ALU: m = CH_MASK_ALU;
            CLASS_MUL: m = CH_MASK_MUL;
            CLASS_DIV: m = CH_MASK_DIV;
            CLASS_MEM: m = CH_MASK_MEM;
            default:   m = CH_MASK_NONE;
        endcase
        return m;
    endfunction

    // keeps the low index bits that the register file really has
    function automatic logic [REG_BITS-1:0] reg_mask(input int unsigned bits);
        logic [REG_BITS-1:0] m;
        for (int i = 0; i < REG_BITS; i++)
        begin
            m[i] = (i < bits);
        end
        return m;
    endfunction

endpackage

[hw/rtl/vbp_in_if.sv]
// ----------------------------------------------------------------------------
// vbp_in_if
// instruction channel of the bundle packer: valid, ready and item fields
// ----------------------------------------------------------------------------
interface vbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] op_code;
    logic [2:0] unit_class;
    logic       dest_valid;
    logic [7:0] dest_reg;
    logic       src_a_valid;
    logic [7:0] src_a_reg;
    logic       src_b_valid;
    logic [7:0] src_b_reg;
    logic       last_in_group;

    modport source (
        output valid, op_code, unit_class, dest_valid, dest_reg,
               src_a_valid, src_a_reg, src_b_valid, src_b_reg, last_in_group,
        input  ready
    );

    modport sink (
        input  valid, op_code, unit_class, dest_valid, dest_reg,
               src_a_valid, src_a_reg, src_b_valid, src_b_reg, last_in_group,
        output ready
    );
endinterface

[hw/rtl/vbp_out_if.sv]
// ----------------------------------------------------------------------------
// vbp_out_if
// slot result channel of the bundle packer: valid, ready and result fields
// ----------------------------------------------------------------------------
interface vbp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [2:0] channel;
    logic [7:0] slot_op;
    logic [7:0] slot_dest;
    logic [7:0] slot_src_a;
    logic [7:0] slot_src_b;
    logic [2:0] placed_count;

    modport source (
        output valid, status, channel, slot_op, slot_dest, slot_src_a, slot_src_b,
               placed_count,
        input  ready
    );

    modport sink (
        input  valid, status, channel, slot_op, slot_dest, slot_src_a, slot_src_b,
               placed_count,
        output ready
    );
endinterface

[hw/rtl/vliw_bundle_packer_core.sv]
// ----------------------------------------------------------------------------
// vliw_bundle_packer_core
// packs instructions into a six-channel vliw bundle with waw/raw checks
// ----------------------------------------------------------------------------
// usage
//   in_item  : one instruction per item (opcode, unit class, optional
//              destination and two sources, last_in_group mark)
//   out_item : one slot result per instruction item (status, channel,
//              slot fields, placed count after the item)
//   path     : an accepted item waits in the input register, and its result
//              is written to the result register, where the receiver takes it
//   rate     : one item per cycle while out_item.ready is high; the hazard compare against the six
//              placed destinations and the channel pick are one pass of
//              logic between the input register and the result register
//   stall    : when out_item.ready is low the result register holds, the
//              input register still takes one more item, then in_item.ready
//              drops until the receiver takes the pending result
//   reset    : rst_n clears both valid flags, busy channels, recorded
//              destinations, the close flag and the placed count; the
//              destination store itself needs no clearing
// ----------------------------------------------------------------------------
module vliw_bundle_packer_core #(
    parameter int REG_INDEX_BITS = vbp_pkg::DEFAULT_REG_INDEX_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    vbp_in_if.sink   in_item,
    vbp_out_if.source out_item
);
    import vbp_pkg::*;

    // input register
    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_data_reg;
    item_t   in_data;

    // result register
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    // issue logic
    result_t issue_result;
    update_t issue_update;
    state_t  bundle_state;
    logic    advance;
    logic    in_fire;

    // item moves into the result register when that register is free or emptying
    assign advance        = in_valid_reg && (!out_valid_reg || out_item.ready);
    assign in_item.ready  = !in_valid_reg || advance;
    assign in_fire        = in_item.valid && in_item.ready;

    assign in_data.op_code       = in_item.op_code;
    assign in_data.unit_class    = in_item.unit_class;
    assign in_data.dest_valid    = in_item.dest_valid;
    assign in_data.dest_reg      = in_item.dest_reg;
    assign in_data.src_a_valid   = in_item.src_a_valid;
    assign in_data.src_a_reg     = in_item.src_a_reg;
    assign in_data.src_b_valid   = in_item.src_b_valid;
    assign in_data.src_b_reg     = in_item.src_b_reg;
    assign in_data.last_in_group = in_item.last_in_group;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_item.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= issue_result;
        end
    end

    // decision for the item in the input register against the current bundle
    vbp_issue #(
        .REG_INDEX_BITS (REG_INDEX_BITS)
    ) u_issue (
        .item   (in_data_reg),
        .state  (bundle_state),
        .result (issue_result),
        .update (issue_update)
    );

    // bundle state moves together with the item
    vbp_bundle_state u_state (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd_en (advance),
        .update (issue_update),
        .state  (bundle_state)
    );

    assign out_item.valid        = out_valid_reg;
    assign out_item.status       = out_data_reg.status;
    assign out_item.channel      = out_data_reg.channel;
    assign out_item.slot_op      = out_data_reg.slot_op;
    assign out_item.slot_dest    = out_data_reg.slot_dest;
    assign out_item.slot_src_a   = out_data_reg.slot_src_a;
    assign out_item.slot_src_b   = out_data_reg.slot_src_b;
    assign out_item.placed_count = out_data_reg.placed_count;

endmodule

[hw/rtl/vbp_issue.sv]
// ----------------------------------------------------------------------------
// vbp_issue
// hazard check against placed destinations and lowest free channel pick
// ----------------------------------------------------------------------------
module vbp_issue #(
    parameter int REG_INDEX_BITS = vbp_pkg::DEFAULT_REG_INDEX_BITS
) (
    input  vbp_pkg::item_t   item,
    input  vbp_pkg::state_t  state,
    output vbp_pkg::result_t result,
    output vbp_pkg::update_t update
);
    import vbp_pkg::*;

    localparam logic [REG_BITS-1:0] REG_MASK = reg_mask(REG_INDEX_BITS);

    logic [REG_BITS-1:0]     dreg;
    logic [REG_BITS-1:0]     areg;
    logic [REG_BITS-1:0]     breg;
    logic                    hazard;
    logic [NUM_CHANNELS-1:0] free_mask;
    logic [CH_BITS-1:0]      pick;
    logic                    found;

    assign dreg      = item.dest_reg & REG_MASK;
    assign areg      = item.src_a_reg & REG_MASK;
    assign breg      = item.src_b_reg & REG_MASK;
    assign free_mask = class_mask(item.unit_class) & ~state.busy_mask;

    // six parallel compares against placed destinations
    always_comb
    begin
        hazard = 1'b0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            if (state.written_valid[ch] &&
                ((item.dest_valid  && dreg == state.written_regs[ch]) ||
                 (item.src_a_valid && areg == state.written_regs[ch]) ||
                 (item.src_b_valid && breg == state.written_regs[ch])))
            begin
                hazard = 1'b1;
            end
        end
    end

    // lowest set bit of the free mask
    always_comb
    begin
        pick  = '0;
        found = 1'b0;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            if (free_mask[ch] && !found)
            begin
                pick  = CH_BITS'(ch);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        result              = '0;
        result.status       = STATUS_SKIPPED;
        result.placed_count = state.placed_total;

        update            = '0;
        update.clear      = item.last_in_group;
        update.pick       = pick;
        update.dest_reg   = dreg;

        if (!state.bundle_closed)
        begin
            if (hazard)
            begin
                result.status = STATUS_HAZARD;
                update.close  = 1'b1;
            end
            else if (!found)
            begin
                result.status = STATUS_NO_CHANNEL;
                update.close  = 1'b1;
            end
            else
            begin
                result.status       = STATUS_PLACED;
                result.channel      = pick;
                result.slot_op      = item.op_code;
                result.slot_dest    = item.dest_valid  ? dreg : '0;
                result.slot_src_a   = item.src_a_valid ? areg : '0;
                result.slot_src_b   = item.src_b_valid ? breg : '0;
                result.placed_count = state.placed_total + COUNT_BITS'(1);
                update.place        = 1'b1;
                update.write_dest   = item.dest_valid;
            end
        end
    end

endmodule

[hw/rtl/vbp_bundle_state.sv]
// ----------------------------------------------------------------------------
// vbp_bundle_state
// busy channels, placed destinations, close flag and placed count of a bundle
// ----------------------------------------------------------------------------
module vbp_bundle_state (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             upd_en,
    input  vbp_pkg::update_t update,
    output vbp_pkg::state_t  state
);
    import vbp_pkg::*;

    logic [NUM_CHANNELS-1:0] busy_mask_reg;
    logic [NUM_CHANNELS-1:0] busy_mask_next;
    logic [NUM_CHANNELS-1:0] written_valid_reg;
    logic [NUM_CHANNELS-1:0] written_valid_next;
    logic                    bundle_closed_reg;
    logic                    bundle_closed_next;
    logic [COUNT_BITS-1:0]   placed_total_reg;
    logic [COUNT_BITS-1:0]   placed_total_next;
    logic [REG_BITS-1:0]     written_regs_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] pick_onehot;

    assign pick_onehot = NUM_CHANNELS'(1) << update.pick;

    always_comb
    begin
        busy_mask_next     = busy_mask_reg;
        written_valid_next = written_valid_reg;
        bundle_closed_next = bundle_closed_reg;
        placed_total_next  = placed_total_reg;
        if (upd_en)
        begin
            if (update.clear)
            begin
                busy_mask_next     = '0;
                written_valid_next = '0;
                bundle_closed_next = 1'b0;
                placed_total_next  = '0;
            end
            else
            begin
                if (update.place)
                begin
                    busy_mask_next    = busy_mask_reg | pick_onehot;
                    placed_total_next = placed_total_reg + COUNT_BITS'(1);
                end
                if (update.place && update.write_dest)
                begin
                    written_valid_next = written_valid_reg | pick_onehot;
                end
                if (update.close)
                begin
                    bundle_closed_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_mask_reg     <= '0;
            written_valid_reg <= '0;
            bundle_closed_reg <= 1'b0;
            placed_total_reg  <= '0;
        end
        else
        begin
            busy_mask_reg     <= busy_mask_next;
            written_valid_reg <= written_valid_next;
            bundle_closed_reg <= bundle_closed_next;
            placed_total_reg  <= placed_total_next;
        end
    end

    // destination store, read only where written_valid is set
    always_ff @(posedge clk)
    begin
        if (upd_en && update.place && update.write_dest)
        begin
            written_regs_reg[update.pick] <= update.dest_reg;
        end
    end

    always_comb
    begin
        state.busy_mask     = busy_mask_reg;
        state.written_valid = written_valid_reg;
        state.bundle_closed = bundle_closed_reg;
        state.placed_total  = placed_total_reg;
        for (int ch = 0; ch < NUM_CHANNELS; ch++)
        begin
            state.written_regs[ch] = written_regs_reg[ch];
        end
    end

    // each placed item occupies exactly one channel
    a_count_matches_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(busy_mask_reg) == int'(placed_total_reg))
        else $error("placed count differs from busy channel count");

    // a destination is only recorded on an occupied channel
    a_dest_on_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (written_valid_reg & ~busy_mask_reg) == '0)
        else $error("destination recorded on a free channel");

    // the last item of a group leaves a clean bundle
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_en && update.clear) |=>
            (busy_mask_reg == '0 && written_valid_reg == '0 && !bundle_closed_reg))
        else $error("bundle state not cleared after last item");

endmodule
